// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/slsc_pkg.sv
// ---------------------------------------------------------------------------
// slsc_pkg
// Types, byte constants and helpers for the shell line syntax checker.
// ---------------------------------------------------------------------------
package slsc_pkg;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_PIPE = 8'h7C;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_SQ   = 8'h27;
   localparam logic [7:0] CH_DQ   = 8'h22;

   typedef enum logic [3:0] {
      ST_OK         = 4'd0,
      ST_PIPE       = 4'd1,
      ST_NEWLINE    = 4'd2,
      ST_GT         = 4'd3,
      ST_GTGT       = 4'd4,
      ST_LT         = 4'd5,
      ST_LTLT       = 4'd6,
      ST_EOF_PIPE   = 4'd7,
      ST_OPEN_QUOTE = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_SINGLE = 2'd1,
      Q_DOUBLE = 2'd2
   } quote_type;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_PIPE    = 3'd1,
      MODE_REDIR1  = 3'd2,
      MODE_REDIR   = 3'd3,
      MODE_DECIDE  = 3'd4,
      MODE_STOPPED = 3'd5
   } mode_type;

   typedef struct packed {
      quote_type  quote;
      logic       seen;
      mode_type   mode;
      logic [7:0] rchar;
      status_type err;
   } state_type;

   localparam state_type STATE_RESET = '{
      quote: Q_NONE, seen: 1'b0, mode: MODE_IDLE, rchar: 8'h00, err: ST_OK
   };

   typedef struct packed {
      status_type status;
      logic       open_double;
   } result_type;

   function automatic logic is_blank(logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic is_redir(logic [7:0] b);
      return (b == CH_GT) || (b == CH_LT);
   endfunction

   function automatic status_type redir_code(logic [7:0] c, logic doubled);
      if (c == CH_GT) begin
         return doubled ? ST_GTGT : ST_GT;
      end
      return doubled ? ST_LTLT : ST_LT;
   endfunction

endpackage

// File: rtl/slsc_step.sv
// ---------------------------------------------------------------------------
// slsc_step
// Next-state and end-of-line status logic for one request.
// ---------------------------------------------------------------------------
module slsc_step (
   input  slsc_pkg::state_type  state_ff,
   input  logic [7:0]           ch,
   output slsc_pkg::state_type  state_next,
   output slsc_pkg::result_type result
);
   import slsc_pkg::*;

   function automatic state_type idle_byte(state_type s, logic [7:0] b);
      state_type n;
      n = s;
      if ((s.quote == Q_NONE) && (b == CH_HASH)) begin
         n.mode = MODE_STOPPED;
      end else if ((b == CH_SQ) || (b == CH_DQ)) begin
         if (s.quote == Q_NONE) begin
            n.quote = (b == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
         end else if (((s.quote == Q_SINGLE) && (b == CH_SQ)) ||
                      ((s.quote == Q_DOUBLE) && (b == CH_DQ))) begin
            n.quote = Q_NONE;
         end
      end else if ((s.quote == Q_NONE) && (b == CH_PIPE)) begin
         if (!s.seen) begin
            n.err  = ST_PIPE;
            n.mode = MODE_IDLE;
         end else begin
            n.mode = MODE_PIPE;
         end
      end else if ((s.quote == Q_NONE) && is_redir(b)) begin
         n.mode  = MODE_REDIR1;
         n.rchar = b;
      end
      return n;
   endfunction

   function automatic state_type redir_byte(state_type s, logic [7:0] b);
      state_type n;
      n = s;
      if (is_blank(b)) begin
         n.mode = MODE_REDIR;
      end else if (b == CH_PIPE) begin
         n.err  = ST_PIPE;
         n.mode = MODE_IDLE;
      end else if (is_redir(b)) begin
         n.mode  = MODE_DECIDE;
         n.rchar = b;
      end else begin
         n.mode = MODE_IDLE;
         n      = idle_byte(n, b);
      end
      return n;
   endfunction

   state_type taken;

   always_comb begin
      taken = state_ff;
      unique case (state_ff.mode)
         MODE_IDLE: begin
            taken = idle_byte(state_ff, ch);
         end
         MODE_PIPE: begin
            if (ch == CH_PIPE) begin
               taken.err  = ST_PIPE;
               taken.mode = MODE_IDLE;
            end else if (!is_blank(ch)) begin
               taken.mode = MODE_IDLE;
               taken      = idle_byte(taken, ch);
            end
         end
         MODE_REDIR1: begin
            if (ch == state_ff.rchar) begin
               taken.mode = MODE_REDIR;
            end else begin
               taken = redir_byte(state_ff, ch);
            end
         end
         MODE_REDIR: begin
            taken = redir_byte(state_ff, ch);
         end
         MODE_DECIDE: begin
            taken.err  = redir_code(state_ff.rchar, ch == state_ff.rchar);
            taken.mode = MODE_IDLE;
         end
         default: begin
            taken = state_ff;
         end
      endcase
      if (!is_blank(ch)) begin
         taken.seen = 1'b1;
      end
   end

   // hold everything once an error is latched or a comment has started
   assign state_next = ((state_ff.err != ST_OK) || (state_ff.mode == MODE_STOPPED))
                       ? state_ff : taken;

   always_comb begin
      result.open_double = 1'b0;
      if (state_ff.err != ST_OK) begin
         result.status = state_ff.err;
      end else if (state_ff.mode == MODE_PIPE) begin
         result.status = ST_EOF_PIPE;
      end else if ((state_ff.mode == MODE_REDIR1) || (state_ff.mode == MODE_REDIR)) begin
         result.status = ST_NEWLINE;
      end else if (state_ff.mode == MODE_DECIDE) begin
         result.status = redir_code(state_ff.rchar, 1'b0);
      end else if (state_ff.quote != Q_NONE) begin
         result.status      = ST_OPEN_QUOTE;
         result.open_double = (state_ff.quote == Q_DOUBLE);
      end else begin
         result.status = ST_OK;
      end
   end

endmodule

// File: rtl/shell_line_syntax_checker.sv
// ---------------------------------------------------------------------------
// shell_line_syntax_checker
// Byte-stream syntax check of shell command lines.
// ---------------------------------------------------------------------------
// Usage:
//   Send a command line on the req_ channel, one byte per request in
//   req_tdata, then one request with req_tlast high to end the line (its
//   byte is ignored). Each end-of-line request yields one status on the
//   rsp_ channel; byte requests yield nothing.
//   Requests land in an input register; the parser state and the result
//   register are updated from it through one level of logic.
//   Path: an accepted end-of-line request passes the input register, then
//   the result register, where its status raises rsp_tvalid.
//   Throughput: one request per cycle, sustained while no end-of-line request stalls.
//   Stall: while a status waits in the result register, byte requests
//   still flow; a following end-of-line request waits in the input
//   register until the status is taken, so req_tready drops only then.
//   Reset clears the parser state and both valid flags; the block then
//   starts on a fresh line. After each end of line the state clears too.
// ---------------------------------------------------------------------------
module shell_line_syntax_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tlast,   // end_mark
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [3:0] status, [4] open_double, [7:5] zero
);
   import slsc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;
   logic       fire;

   state_type  state_ff, state_in, state_next;
   result_type result;

   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   slsc_step u_step (
      .state_ff   (state_ff),
      .ch         (in_ch_ff),
      .state_next (state_next),
      .result     (result)
   );

   // an end-of-line request may only advance when the result slot frees up
   assign fire = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      state_in    = state_ff;
      if (fire) begin
         state_in = in_last_ff ? STATE_RESET : state_next;
      end
      out_valid_in = (fire && in_last_ff) || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      if (req_tready) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (fire && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.open_double, out_ff.status};

endmodule

// File: rtl/slsc_checker.sv
// ---------------------------------------------------------------------------
// slsc_checker
// Port-level assertions for the shell line syntax checker.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module slsc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import slsc_pkg::*;

   // a stalled status holds
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // status within its range and padding clear
   `ASSERT_RST(a_rsp_range, clock, reset, rsp_tvalid |-> rsp_tdata[7:5] == 3'b000 && rsp_tdata[3:0] <= ST_OPEN_QUOTE)
   // quote kind only reported with an open quote
   `ASSERT_RST(a_dbl_quote, clock, reset, rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3:0] == ST_OPEN_QUOTE)
   // nothing comes out straight after reset
   `ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_tvalid)
   // with the result slot empty the input side always takes a request
   `ASSERT_RST(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready)

endmodule

bind shell_line_syntax_checker slsc_checker u_slsc_checker (.*);

// File: test/shell_line_syntax_checker_test.sv
// ----------------------------------------------------------------------------
// Shell line syntax checker: self-checking stream test
// Drives command lines a byte at a time on the request channel, ended by an
// end-of-line request. A built-in model of the parser predicts each status.
// A short table of hand-written lines comes first. Random lines follow, built
// from words, blanks, pipes, redirections, quotes and comments, mixed with
// raw byte noise. Both channels idle at random, and the receiver holds off
// once for a long stretch so that the block stalls its input.
// ----------------------------------------------------------------------------
module shell_line_syntax_checker_test;
   timeunit 1ns;
   timeprecision 1ps;

   import slsc_pkg::*;

   localparam int RANDOM_REQUESTS = 1850;
   localparam int HOLD_CYCLES     = 120;
   localparam int HOLD_AFTER      = 40;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DIRECTED_ROWS   = 31;

   localparam logic [7:0] BLANK_BYTES [0:5] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       typed;
      status_type status;
      logic       open_double;
   } line_row_type;

   // Hand-written lines; the status is typed in on each end-of-line row
   localparam line_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{8'hFF,   1'b1, 1'b1, ST_OK,         1'b0},
      '{CH_PIPE, 1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_SQ,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_PIPE,       1'b0},
      '{8'h00,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_PIPE, 1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_EOF_PIPE,   1'b0},
      '{CH_GT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h41,   1'b1, 1'b1, ST_NEWLINE,    1'b0},
      '{CH_LT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_GT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_GT,         1'b0},
      '{CH_LT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_GT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_GT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_GTGT,       1'b0},
      '{CH_GT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_LT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_LT,         1'b0},
      '{CH_GT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_LT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_LT,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_LTLT,       1'b0},
      '{CH_SQ,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_OPEN_QUOTE, 1'b0},
      '{CH_DQ,   1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_OPEN_QUOTE, 1'b1},
      '{8'hFF,   1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_HASH, 1'b0, 1'b0, ST_OK,         1'b0},
      '{CH_PIPE, 1'b0, 1'b0, ST_OK,         1'b0},
      '{8'h00,   1'b1, 1'b1, ST_OK,         1'b0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] ch
   logic       req_tlast = 1'b0;    // end_mark
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [3:0] status, [4] open_double, [7:5] zero

   result_type status_queue [$];
   int         mismatches = 0;
   int         requests_sent = 0;
   int         random_requests = 0;
   int         lines_sent = 0;
   int         statuses_checked = 0;
   int         cycle_count = 0;
   logic [8:0] statuses_seen = '0;
   logic       sender_calm = 1'b0;

   // Parser model state
   quote_type  line_quote;
   logic       line_seen;
   mode_type   line_mode;
   logic [7:0] line_redir;
   status_type line_error;

   shell_line_syntax_checker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d statuses outstanding", cycle_count,
                  status_queue.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      mismatches++;
   endtask

   function automatic logic blank_char(input logic [7:0] b);
      case (b)
         8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic status_type redirect_token(input logic [7:0] c, input logic doubled);
      case ({c == CH_GT, doubled})
         2'b11:   return ST_GTGT;
         2'b10:   return ST_GT;
         2'b01:   return ST_LTLT;
         default: return ST_LT;
      endcase
   endfunction

   function automatic void clear_line();
      line_quote = Q_NONE;
      line_seen  = 1'b0;
      line_mode  = MODE_IDLE;
      line_redir = 8'h00;
      line_error = ST_OK;
   endfunction

   function automatic void latch_error(input status_type code);
      line_error = code;
      line_mode  = MODE_IDLE;
   endfunction

   function automatic void plain_byte(input logic [7:0] b);
      if (line_quote == Q_NONE && b == CH_HASH) begin
         line_mode = MODE_STOPPED;
      end else if (b == CH_SQ || b == CH_DQ) begin
         if (line_quote == Q_NONE) begin
            line_quote = (b == CH_SQ) ? Q_SINGLE : Q_DOUBLE;
         end else if ((line_quote == Q_SINGLE && b == CH_SQ) ||
                      (line_quote == Q_DOUBLE && b == CH_DQ)) begin
            line_quote = Q_NONE;
         end
      end else if (line_quote == Q_NONE && b == CH_PIPE) begin
         if (!line_seen) begin
            latch_error(ST_PIPE);
         end else begin
            line_mode = MODE_PIPE;
         end
      end else if (line_quote == Q_NONE && (b == CH_GT || b == CH_LT)) begin
         line_mode  = MODE_REDIR1;
         line_redir = b;
      end
   endfunction

   // Doubling already settled: look for the operand of the redirection
   function automatic void after_redirect(input logic [7:0] b);
      if (blank_char(b)) begin
         line_mode = MODE_REDIR;
      end else if (b == CH_PIPE) begin
         latch_error(ST_PIPE);
      end else if (b == CH_GT || b == CH_LT) begin
         line_mode  = MODE_DECIDE;
         line_redir = b;
      end else begin
         line_mode = MODE_IDLE;
         plain_byte(b);
      end
   endfunction

   function automatic logic predict_request(input logic [7:0] ch, input logic last,
                                            output result_type res);
      res = '0;
      if (!last) begin
         if (line_error == ST_OK && line_mode != MODE_STOPPED) begin
            case (line_mode)
               MODE_IDLE: plain_byte(ch);
               MODE_PIPE: begin
                  if (ch == CH_PIPE) begin
                     latch_error(ST_PIPE);
                  end else if (!blank_char(ch)) begin
                     line_mode = MODE_IDLE;
                     plain_byte(ch);
                  end
               end
               MODE_REDIR1: begin
                  if (ch == line_redir) begin
                     line_mode = MODE_REDIR;
                  end else begin
                     after_redirect(ch);
                  end
               end
               MODE_REDIR:  after_redirect(ch);
               MODE_DECIDE: latch_error(redirect_token(line_redir, ch == line_redir));
               default: ;
            endcase
            if (!blank_char(ch)) begin
               line_seen = 1'b1;
            end
         end
         return 1'b0;
      end
      if (line_error != ST_OK) begin
         res.status = line_error;
      end else begin
         case (line_mode)
            MODE_PIPE:               res.status = ST_EOF_PIPE;
            MODE_REDIR1, MODE_REDIR: res.status = ST_NEWLINE;
            MODE_DECIDE:             res.status = redirect_token(line_redir, 1'b0);
            default: begin
               if (line_quote != Q_NONE) begin
                  res.status      = ST_OPEN_QUOTE;
                  res.open_double = (line_quote == Q_DOUBLE);
               end else begin
                  res.status = ST_OK;
               end
            end
         endcase
      end
      clear_line();
      return 1'b1;
   endfunction

   // Offer one request, wait for it to be taken, then queue its status if any
   task automatic send_request(input logic [7:0] ch, input logic last, input logic typed_row,
                               input result_type typed);
      int         gap;
      result_type predicted;
      logic       produces;
      gap = sender_calm ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      if (last) begin
         lines_sent++;
      end
      produces = predict_request(ch, last, predicted);
      if (produces) begin
         status_queue.push_back(typed_row ? typed : predicted);
      end
   endtask

   task automatic send_random_line();
      logic [7:0] text [$];
      logic [7:0] q;
      int         tokens;
      sender_calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
         // raw byte noise
         repeat ($urandom_range(0, 10)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         tokens = $urandom_range(0, 8);
         repeat (tokens) begin
            case ($urandom_range(0, 11))
               0, 1, 2: repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(8'h61, 8'h7A)));
               3, 4:    repeat ($urandom_range(1, 2)) text.push_back(BLANK_BYTES[3'($urandom_range(0, 5))]);
               5:       text.push_back(CH_PIPE);
               6, 7: begin
                  q = $urandom_range(0, 1) ? CH_GT : CH_LT;
                  repeat ($urandom_range(1, 3)) text.push_back(q);
               end
               8, 9: begin
                  q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
                  text.push_back(q);
                  repeat ($urandom_range(0, 3)) begin
                     case ($urandom_range(0, 5))
                        0:       text.push_back(CH_SQ);
                        1:       text.push_back(CH_DQ);
                        2:       text.push_back(CH_PIPE);
                        3:       text.push_back(CH_HASH);
                        4:       text.push_back(CH_GT);
                        default: text.push_back(8'($urandom_range(8'h61, 8'h7A)));
                     endcase
                  end
                  // leave the quote open now and then
                  if ($urandom_range(0, 7) != 0) begin
                     text.push_back(q);
                  end
               end
               10:      text.push_back(CH_HASH);
               default: text.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end
      foreach (text[i]) begin
         send_request(text[i], 1'b0, 1'b0, '0);
      end
      send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      random_requests += text.size() + 1;
   endtask

   // Result side: random stalls, calm runs, and one long hold-off
   initial begin : drain
      int stall;
      int taken;
      int calm;
      taken = 0;
      calm  = 0;
      wait (reset == 1'b0);
      forever begin
         if (taken == HOLD_AFTER) begin
            stall = HOLD_CYCLES;
         end else if (calm > 0) begin
            stall = 0;
            calm--;
         end else begin
            stall = $urandom_range(0, 4);
            if ($urandom_range(0, 15) == 0) begin
               calm = 24;
            end
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         taken++;
      end
   end

   always @(posedge clock) begin : check_status
      result_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (status_queue.size() == 0) begin
            report_mismatch($sformatf("status %0d returned with none expected", rsp_tdata[3:0]));
         end else begin
            want = status_queue.pop_front();
            statuses_checked++;
            if (rsp_tdata[3:0] !== want.status) begin
               report_mismatch($sformatf("status %0d, expected %0d", rsp_tdata[3:0], want.status));
            end
            if (rsp_tdata[4] !== want.open_double) begin
               report_mismatch($sformatf("open_double %b, expected %b", rsp_tdata[4],
                                         want.open_double));
            end
            if (rsp_tdata[7:5] !== 3'b000) begin
               report_mismatch($sformatf("padding bits %b not zero", rsp_tdata[7:5]));
            end
         end
         if (rsp_tdata[3:0] <= 4'd8) begin
            statuses_seen[rsp_tdata[3:0]] = 1'b1;
         end
      end
   end

   initial begin : stimulus
      result_type typed;
      clear_line();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         typed.status      = DIRECTED[5'(i)].status;
         typed.open_double = DIRECTED[5'(i)].open_double;
         send_request(DIRECTED[5'(i)].ch, DIRECTED[5'(i)].last, DIRECTED[5'(i)].typed, typed);
      end
      while (random_requests < RANDOM_REQUESTS) send_random_line();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d lines over %0d requests, %0d statuses compared, %0d mismatches",
               lines_sent, requests_sent, statuses_checked, mismatches);
      $display("status codes returned, one bit per code from 8 down to 0: %b; one %0d-cycle hold-off",
               statuses_seen, HOLD_CYCLES);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
